>>> rtl/pvs_pkg.sv
// ----------------------------------------------------------------------------
// pvs_pkg
// Types and constants shared by the voice bank modules.
// ----------------------------------------------------------------------------
package pvs_pkg;

	typedef struct packed {
		logic [31:0]        phase;
		logic [31:0]        step;
		logic [15:0]        amp;
		logic               on;
		logic [2:0]         wave;
		logic [11:0]        click;
		logic [15:0]        gain;
		logic signed [15:0] mem;
	} voice_t;

	localparam logic [2:0] WAVE_SINE  = 3'd0;
	localparam logic [2:0] WAVE_TRI   = 3'd1;
	localparam logic [2:0] WAVE_SQR   = 3'd2;
	localparam logic [2:0] WAVE_SAW   = 3'd3;
	localparam logic [2:0] WAVE_CLICK = 3'd4;
	localparam logic [2:0] WAVE_NOISE = 3'd5;

	localparam logic [1:0] CFG_DECAY_LONG   = 2'd0;
	localparam logic [1:0] CFG_DECAY_SHORT  = 2'd1;
	localparam logic [1:0] CFG_CLICK_LENGTH = 2'd2;

	localparam logic [15:0] DECAY_LONG_RST   = 16'd65519;
	localparam logic [15:0] DECAY_SHORT_RST  = 16'd65445;
	localparam logic [11:0] CLICK_LENGTH_RST = 12'd192;

	localparam logic [15:0] AMP_START    = 16'd32768;
	localparam logic [15:0] AMP_IDLE     = 16'd66;
	localparam logic [16:0] SQUARE_LEVEL = 17'd26214;
	localparam logic [15:0] CLICK_GAIN   = 16'd19661;
	localparam logic [16:0] SIN_C1       = 17'd102944;
	localparam logic [15:0] SIN_C3       = 16'd42334;
	localparam logic [12:0] SIN_C5       = 13'd5223;
	localparam logic [31:0] LFSR_TAPS    = 32'h80200003;
	localparam logic [31:0] LFSR_SEED    = 32'hACE1ACE1;

endpackage

>>> rtl/pvs_if.sv
// ----------------------------------------------------------------------------
// pvs_req_if / pvs_rsp_if
// Valid/ready channels for requests and mixed samples.
// ----------------------------------------------------------------------------
interface pvs_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] phase_step;
	logic [2:0]  wave_type;
	logic [15:0] lp_coeff;
	modport source (output valid, action, phase_step, wave_type, lp_coeff, input ready);
	modport sink (input valid, action, phase_step, wave_type, lp_coeff, output ready);
endinterface

interface pvs_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mixed_sample;
	logic [3:0]         voices_active;
	modport source (output valid, mixed_sample, voices_active, input ready);
	modport sink (input valid, mixed_sample, voices_active, output ready);
endinterface

>>> rtl/pvs_cell.sv
// ----------------------------------------------------------------------------
// pvs_cell
// One voice slot of the ring; takes its neighbor's voice on each shift.
// ----------------------------------------------------------------------------
module pvs_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  pvs_pkg::voice_t d,
	output pvs_pkg::voice_t q
);
	import pvs_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (shift) begin
			q <= d;
		end
	end

endmodule

>>> rtl/pvs_render.sv
// ----------------------------------------------------------------------------
// pvs_render
// Renders one voice over eight steps: waveform, gain, filter, decay.
// ----------------------------------------------------------------------------
module pvs_render #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pvs_pkg::voice_t voice_in,
	input  logic [15:0]     decay_long,
	input  logic [15:0]     decay_short,
	output logic            done,
	output pvs_pkg::voice_t voice_out
);
	import pvs_pkg::*;

	localparam int QB = SINE_TABLE_BITS - 2;

	localparam logic [3:0] RS_IDLE   = 4'd0;
	localparam logic [3:0] RS_X2     = 4'd1;
	localparam logic [3:0] RS_T      = 4'd2;
	localparam logic [3:0] RS_U      = 4'd3;
	localparam logic [3:0] RS_SINE   = 4'd4;
	localparam logic [3:0] RS_SAMPLE = 4'd5;
	localparam logic [3:0] RS_SCALE  = 4'd6;
	localparam logic [3:0] RS_FILTER = 4'd7;
	localparam logic [3:0] RS_DONE   = 4'd8;

	logic [3:0]         step_q;
	voice_t             v_q;
	logic [31:0]        lfsr_q;
	logic [16:0]        x_q;
	logic [16:0]        x2_q;
	logic [15:0]        t_q;
	logic [16:0]        u_q;
	logic               neg_q;
	logic signed [15:0] sine_q;
	logic signed [16:0] noise_q;
	logic signed [16:0] sample_q;
	logic signed [17:0] scaled_q;

	logic [SINE_TABLE_BITS-1:0] idx;
	logic [QB-1:0]              r;
	logic [QB:0]                pos;
	logic [16:0]                x_c;
	logic [31:0]                lfsr_n;
	logic [29:0]                p1;
	logic [32:0]                p2;
	logic [33:0]                p3;
	logic [16:0]                s_c;
	logic signed [31:0]         clk_p;
	logic signed [17:0]         tri_c;
	logic signed [16:0]         smp_c;
	logic signed [33:0]         sc_p;
	logic signed [18:0]         diff;
	logic signed [35:0]         fp;
	logic signed [20:0]         mem_c;
	logic signed [15:0]         mem_sat;
	logic [15:0]                decay;
	logic [31:0]                amp_p;

	always_comb begin
		idx = voice_in.phase[31 -: SINE_TABLE_BITS];
		r = idx[QB-1:0];
		pos = idx[QB] ? ((QB+1)'(1) << QB) - {1'b0, r} : {1'b0, r};
		x_c = 17'(pos) << (18 - SINE_TABLE_BITS);
		lfsr_n = lfsr_q[0] ? ({1'b0, lfsr_q[31:1]} ^ LFSR_TAPS) : {1'b0, lfsr_q[31:1]};
		p1 = 30'(x2_q) * 30'(SIN_C5);
		p2 = 33'(x2_q) * 33'(t_q);
		p3 = 34'(x_q) * 34'(u_q);
		s_c = p3[33:17];
		clk_p = 32'(sine_q) * $signed({16'd0, CLICK_GAIN});
		if (v_q.phase[31:16] < 16'd16384) begin
			tri_c = $signed({1'b0, v_q.phase[31:16], 1'b0});
		end else if (v_q.phase[31:16] < 16'd49152) begin
			tri_c = 18'sd65536 - $signed({1'b0, v_q.phase[31:16], 1'b0});
		end else begin
			tri_c = $signed({1'b0, v_q.phase[31:16], 1'b0}) - 18'sd131072;
		end
		if (tri_c > 18'sd32767) begin
			tri_c = 18'sd32767;
		end
		unique case (v_q.wave)
			WAVE_SINE:  smp_c = 17'(sine_q);
			WAVE_TRI:   smp_c = tri_c[16:0];
			WAVE_SQR:   smp_c = v_q.phase[31] ? -$signed(SQUARE_LEVEL) : $signed(SQUARE_LEVEL);
			WAVE_SAW:   smp_c = 17'($signed({~v_q.phase[31], v_q.phase[30:16]}));
			WAVE_CLICK: smp_c = (v_q.click != 12'd0) ? clk_p[30:14] : 17'sd0;
			WAVE_NOISE: smp_c = noise_q;
			default:    smp_c = 17'sd0;
		endcase
		sc_p = 34'(sample_q) * $signed({18'd0, v_q.amp});
		diff = 19'(scaled_q) - 19'(v_q.mem);
		fp = 36'($signed({1'b0, v_q.gain})) * 36'(diff);
		mem_c = 21'(v_q.mem) + 21'($signed(fp[35:16]));
		if (mem_c > 21'sd32767) begin
			mem_sat = 16'sd32767;
		end else if (mem_c < -21'sd32768) begin
			mem_sat = -16'sd32768;
		end else begin
			mem_sat = mem_c[15:0];
		end
		decay = (v_q.wave == WAVE_CLICK || v_q.wave == WAVE_NOISE) ? decay_short : decay_long;
		amp_p = 32'(v_q.amp) * 32'(decay);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= RS_IDLE;
			lfsr_q <= LFSR_SEED;
		end else begin
			unique case (step_q)
				RS_IDLE: begin
					if (start) begin
						step_q <= RS_X2;
						if (voice_in.wave == WAVE_NOISE) begin
							lfsr_q <= lfsr_n;
						end
					end
				end
				RS_DONE: step_q <= RS_IDLE;
				default: step_q <= step_q + 4'd1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (step_q)
			RS_IDLE: begin
				if (start) begin
					v_q <= voice_in;
					x_q <= x_c;
					neg_q <= idx[QB+1];
					noise_q <= 17'($signed({~lfsr_n[31], lfsr_n[30:16]}));
				end
			end
			RS_X2: x2_q <= 17'((34'(x_q) * 34'(x_q)) >> 16);
			RS_T: t_q <= SIN_C3 - 16'(p1[29:16]);
			RS_U: u_q <= SIN_C1 - 17'(p2[32:16]);
			RS_SINE: begin
				if (s_c > 17'd32767) begin
					sine_q <= neg_q ? -16'sd32767 : 16'sd32767;
				end else begin
					sine_q <= neg_q ? -$signed(s_c[15:0]) : $signed(s_c[15:0]);
				end
			end
			RS_SAMPLE: begin
				sample_q <= smp_c;
				if (v_q.wave == WAVE_CLICK && v_q.click != 12'd0) begin
					v_q.click <= v_q.click - 12'd1;
				end
			end
			RS_SCALE: scaled_q <= sc_p[33:16];
			RS_FILTER: begin
				v_q.mem <= mem_sat;
				v_q.phase <= v_q.phase + v_q.step;
				v_q.amp <= amp_p[31:16];
				v_q.on <= (amp_p[31:16] >= AMP_IDLE);
			end
			default: ;
		endcase
	end

	assign done = (step_q == RS_DONE);
	assign voice_out = v_q;

endmodule

>>> rtl/polyphonic_voice_synth.sv
// ----------------------------------------------------------------------------
// polyphonic_voice_synth
// Polyphonic oscillator voice bank with voice stealing.
// ----------------------------------------------------------------------------
// Requests arrive on req. A trigger (action 1) picks the first idle voice,
// else the quietest one, and restarts it; it gives no sample. A tick
// (action 0) renders all active voices and returns one transfer on rsp with
// the saturated mix and the count of voices still active.
// Voices sit in a ring of cells that rotates one slot per cycle past a
// shared render unit, except when idle or while a voice is rendered. A
// trigger makes two laps of the ring (one lap to choose, one to write). A
// tick visits each voice slot, runs the render steps for each active voice,
// and then loads the result. Each request is accepted in the idle state.
// One request is worked on at a time; req.ready is high only when idle.
// A finished sample waits in the output register; while rsp stalls, the
// next request is accepted and worked on, and a tick ends waiting for rsp.
// Reset clears all voices to idle, seeds the noise generator and loads the
// default decay and click settings.
// ----------------------------------------------------------------------------
module polyphonic_voice_synth #(
	parameter int VOICE_COUNT = 8,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	pvs_req_if.sink       req,
	pvs_rsp_if.source     rsp,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	import pvs_pkg::*;

	localparam int PW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int CW = $clog2(VOICE_COUNT + 1);
	localparam int MW = 16 + CW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_WRITE = 3'd2;
	localparam logic [2:0] ST_TICK = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]           state_q;
	logic [PW-1:0]        pos_q;
	logic [PW-1:0]        target_q;
	logic                 found_q;
	logic [16:0]          min_q;
	logic [15:0]          decay_long_q;
	logic [15:0]          decay_short_q;
	logic [11:0]          click_len_q;
	voice_t               new_q;
	logic signed [MW-1:0] mix_q;
	logic [CW-1:0]        count_q;
	logic                 rsp_valid_q;
	logic signed [15:0]   rsp_sample_q;
	logic [3:0]           rsp_count_q;

	voice_t               ring [VOICE_COUNT];
	voice_t               head;
	voice_t               wb;
	voice_t               r_out;
	logic                 shift;
	logic                 r_start;
	logic                 r_done;
	logic                 last;
	logic                 rsp_free;
	logic [31:0]          cnt32;

	assign head = ring[0];
	assign last = (pos_q == PW'(VOICE_COUNT - 1));
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign cnt32 = 32'(count_q);

	always_comb begin
		shift = 1'b0;
		wb = head;
		r_start = 1'b0;
		unique case (state_q)
			ST_SCAN: shift = 1'b1;
			ST_WRITE: begin
				shift = 1'b1;
				if (pos_q == target_q) begin
					wb = new_q;
				end
			end
			ST_TICK: begin
				r_start = head.on;
				shift = !head.on;
			end
			ST_WAIT: begin
				shift = r_done;
				wb = r_out;
			end
			default: ;
		endcase
	end

	for (genvar i = 0; i < VOICE_COUNT; i++) begin : g_ring
		if (i == VOICE_COUNT - 1) begin : g_tail
			pvs_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .d(wb), .q(ring[i]));
		end else begin : g_body
			pvs_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .d(ring[i+1]),
				.q(ring[i]));
		end
	end

	pvs_render #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_render (
		.clk(clk),
		.arst_n(arst_n),
		.start(r_start),
		.voice_in(head),
		.decay_long(decay_long_q),
		.decay_short(decay_short_q),
		.done(r_done),
		.voice_out(r_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_long_q <= DECAY_LONG_RST;
			decay_short_q <= DECAY_SHORT_RST;
			click_len_q <= CLICK_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DECAY_LONG: decay_long_q <= cfg_data;
				CFG_DECAY_SHORT: decay_short_q <= cfg_data;
				CFG_CLICK_LENGTH: click_len_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					pos_q <= '0;
					if (req.valid) begin
						state_q <= req.action ? ST_SCAN : ST_TICK;
					end
				end
				ST_SCAN: begin
					pos_q <= last ? '0 : pos_q + PW'(1);
					if (last) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					pos_q <= last ? '0 : pos_q + PW'(1);
					if (last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TICK: begin
					if (head.on) begin
						state_q <= ST_WAIT;
					end else begin
						pos_q <= last ? '0 : pos_q + PW'(1);
						if (last) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WAIT: begin
					if (r_done) begin
						pos_q <= last ? '0 : pos_q + PW'(1);
						state_q <= last ? ST_DONE : ST_TICK;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			found_q <= 1'b0;
			min_q <= 17'h10000;
			target_q <= '0;
			mix_q <= '0;
			count_q <= '0;
			new_q.phase <= '0;
			new_q.step <= req.phase_step;
			new_q.amp <= AMP_START;
			new_q.on <= 1'b1;
			new_q.wave <= req.wave_type;
			new_q.click <= (req.wave_type == WAVE_CLICK) ? click_len_q : 12'd0;
			new_q.gain <= req.lp_coeff;
			new_q.mem <= '0;
		end
		if (state_q == ST_SCAN && !found_q) begin
			if (!head.on) begin
				target_q <= pos_q;
				found_q <= 1'b1;
			end else if (17'(head.amp) < min_q) begin
				target_q <= pos_q;
				min_q <= 17'(head.amp);
			end
		end
		if (state_q == ST_WAIT && r_done) begin
			mix_q <= mix_q + MW'(r_out.mem);
			if (r_out.on) begin
				count_q <= count_q + CW'(1);
			end
		end
		if (state_q == ST_DONE && rsp_free) begin
			if (mix_q > MW'(32767)) begin
				rsp_sample_q <= 16'sd32767;
			end else if (mix_q < -MW'(32768)) begin
				rsp_sample_q <= -16'sd32768;
			end else begin
				rsp_sample_q <= mix_q[15:0];
			end
			rsp_count_q <= (cnt32 > 32'd15) ? 4'd15 : cnt32[3:0];
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.mixed_sample = rsp_sample_q;
	assign rsp.voices_active = rsp_count_q;

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && rsp_free |=> rsp.valid)
		else $error("finished tick did not present a sample");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(VOICE_COUNT - 1))
		else $error("ring position out of range");
	a_start_on: assert property (@(posedge clk) disable iff (!arst_n)
		r_start |-> head.on && state_q == ST_TICK)
		else $error("render started on an idle voice");
	a_wait_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT && !r_done |=> $stable(pos_q))
		else $error("ring moved while a voice was rendering");

endmodule
